FILE: hdl/gdx_pkg.sv
package gdx_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W      = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int POS_W      = 24;
  localparam int PIX_W      = 8;
  localparam int DET_W      = 9;
  localparam int CS_W       = 12;
  localparam int HS_W       = 16;
  localparam int NUM_LINES  = 4;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic                  tail;
    logic                  tail_fend;
    logic                  have;
    logic                  c0;
    logic                  emit2;
    logic                  emit3;
    logic                  use_pix;
    logic [3:0][1:0]       tapsel;
    logic [PIX_W-1:0]      pix;
  } ctl_t;

  typedef struct packed {
    logic [DET_W-1:0] detail;
    logic             frame_end;
    logic             run_end;
  } res_t;

  function automatic logic [HS_W-1:0] hsum(logic [CS_W-1:0] a, logic [CS_W-1:0] b,
                                           logic [CS_W-1:0] c, logic [CS_W-1:0] d,
                                           logic [CS_W-1:0] e);
    return HS_W'(a) + (HS_W'(b) << 2) + HS_W'(c) * HS_W'(6) + (HS_W'(d) << 2) + HS_W'(e);
  endfunction

  function automatic logic [DET_W-1:0] detail_f(logic [HS_W-1:0] hs, logic [PIX_W-1:0] center,
                                                logic mode);
    logic [HS_W-1:0]  t;
    logic [PIX_W-1:0] blur;
    logic signed [9:0] d;
    logic signed [9:0] o;
    t    = hs + HS_W'(128);
    blur = t[15:8];
    d    = $signed({2'b00, center}) - $signed({2'b00, blur});
    o    = d + 10'sd128;
    if (o < 10'sd0) o = 10'sd0;
    else if (o > 10'sd255) o = 10'sd255;
    if (o >= 10'sd127 && o <= 10'sd129) o = 10'sd128;
    return mode ? o[DET_W-1:0] : d[DET_W-1:0];
  endfunction

endpackage

FILE: hdl/gdx_if.sv
interface gdx_pix_if import gdx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface gdx_res_if import gdx_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DET_W-1:0] detail;
  logic                    frame_end;
  logic                    run_end;

  modport source (output valid, output detail, output frame_end, output run_end, input ready);
  modport sink (input valid, input detail, input frame_end, input run_end, output ready);
endinterface

FILE: hdl/gdx_ram.sv
module gdx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and write to the same address returns the old word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/gauss5x5_detail_extractor_core.sv
// 5x5 binomial high-pass detail extractor. Pixels arrive in raster order, one per clock
// while ready is high; each result is the source pixel minus its 1-4-6-4-1 blur (edge
// replication on all borders), as signed detail in mode 0 or as an offset-128 clamped byte
// with a dead zone around 128 in mode 1. Four line memories (one per row slot) are read at
// the current column on every accepted item and the pixel is written back in the same
// cycle, so the block takes one item per clock while the output queue has room; each item
// is registered into stage B and then stage C before its results enter an 8-entry output
// queue. Results trail the input by two rows and two columns: after the frame's last pixel
// send 2*width+1 flush items to release the rest. The line memories need no clearing pass.
module gauss5x5_detail_extractor_core import gdx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  gdx_pix_if.sink              pix_in,
  gdx_res_if.source            res_out
);

  logic [DIM_W-1:0]   image_width, image_height;
  logic               output_mode;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [2*DIM_W-1:0] whp, whm;
  logic [POS_W-1:0]   wh_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      output_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_MODE:   output_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign whp = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
  assign whm = whp - (2*DIM_W)'(1);

  assign w_eff = (image_width == '0) ? DIM_W'(1) :
                 (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == '0) ? DIM_W'(1) :
                 (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
  assign wh_m1 = whm[POS_W-1:0];

  // ---------------- stage A: position tracking, memory access ----------------
  logic [COL_W-1:0] icol, col0, cc, col_next;
  logic [ROW_W-1:0] irow, row0, rr, row_next;
  logic [POS_W-1:0] opos, opos_next;
  logic             tail_pend, tail_pend_next;
  logic             done, ign, proc, wen, last_col;
  logic signed [ROW_W:0] rs, hm1;
  ctl_t             a_ctl;
  logic             accept;

  assign accept = pix_in.valid && pix_in.ready;
  assign hm1    = $signed((ROW_W+1)'(h_eff)) - $signed((ROW_W+1)'(1));

  always_comb begin
    col0 = icol;
    row0 = irow;
    if (col0 >= COL_W'(w_eff)) begin
      col0 = '0;
      row0 = row0 + ROW_W'(1);
    end
    done  = row0 >= ROW_W'(h_eff) + ROW_W'(2);
    ign   = !done && pix_in.flush && (row0 < ROW_W'(h_eff));
    a_ctl = '0;
    a_ctl.pix       = pix_in.pixel;
    a_ctl.tail      = !ign && tail_pend;
    a_ctl.tail_fend = opos == wh_m1;
    opos_next       = opos;
    if (a_ctl.tail) opos_next = opos_next + POS_W'(1);
    tail_pend_next  = ign ? tail_pend : 1'b0;
    rr = row0;
    cc = col0;
    if (done) begin
      opos_next = '0;
      rr = '0;
      cc = '0;
    end
    proc     = !ign && !(done && pix_in.flush);
    last_col = cc == COL_W'(w_eff) - COL_W'(1);
    a_ctl.have    = proc && (rr >= ROW_W'(2));
    a_ctl.c0      = cc == '0;
    a_ctl.emit2   = a_ctl.have && (cc >= COL_W'(2));
    a_ctl.emit3   = a_ctl.have && last_col && (cc >= COL_W'(1));
    a_ctl.use_pix = rr < ROW_W'(h_eff);
    wen           = proc && a_ctl.use_pix && !pix_in.flush;
    if (a_ctl.have && last_col) tail_pend_next = 1'b1;
    opos_next = opos_next + POS_W'(a_ctl.emit2) + POS_W'(a_ctl.emit3);
    for (int i = 0; i < NUM_LINES; i++) begin
      rs = $signed({1'b0, rr}) + $signed((ROW_W+1)'(i)) - $signed((ROW_W+1)'(NUM_LINES));
      if (rs < 0) a_ctl.tapsel[i] = 2'd0;
      else if (rs > hm1) a_ctl.tapsel[i] = hm1[1:0];
      else a_ctl.tapsel[i] = rs[1:0];
    end
    col_next = cc;
    row_next = rr;
    if (proc) begin
      col_next = cc + COL_W'(1);
      if (col_next >= COL_W'(w_eff)) begin
        col_next = '0;
        row_next = rr + ROW_W'(1);
      end
    end
  end

  logic [PIX_W-1:0] rd [NUM_LINES];

  for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
    gdx_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk   (clk),
      .we    (accept && wen && (rr[1:0] == 2'(k))),
      .addr  (cc[ADDR_W-1:0]),
      .wdata (pix_in.pixel),
      .rdata (rd[k])
    );
  end

  logic b_v, c_v;
  ctl_t b_ctl, c_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      icol      <= '0;
      irow      <= '0;
      opos      <= '0;
      tail_pend <= 1'b0;
      b_v       <= 1'b0;
    end else begin
      b_v <= accept && (a_ctl.tail || a_ctl.have);
      if (accept) begin
        icol      <= col_next;
        irow      <= row_next;
        opos      <= opos_next;
        tail_pend <= tail_pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) b_ctl <= a_ctl;
  end

  // ---------------- stage B: vertical pass ----------------
  logic [PIX_W-1:0] t0, t1, t2, t3, cur;
  logic [CS_W-1:0]  col_sum, c_s;
  logic [PIX_W-1:0] c_center;

  assign t0  = rd[b_ctl.tapsel[0]];
  assign t1  = rd[b_ctl.tapsel[1]];
  assign t2  = rd[b_ctl.tapsel[2]];
  assign t3  = rd[b_ctl.tapsel[3]];
  assign cur = b_ctl.use_pix ? b_ctl.pix : t3;
  assign col_sum = CS_W'(t0) + (CS_W'(t1) << 2) + CS_W'(t2) * CS_W'(6) + (CS_W'(t3) << 2)
                 + CS_W'(cur);

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    c_ctl    <= b_ctl;
    c_s      <= col_sum;
    c_center <= t2;
  end

  // ---------------- stage C: horizontal pass, results ----------------
  logic [CS_W-1:0]  win [5];
  logic [CS_W-1:0]  nw [5];
  logic [PIX_W-1:0] dly [3];
  res_t             r_tail, r_e2, r_e3, sl0, sl1;
  logic [1:0]       n, push;

  always_comb begin
    if (c_ctl.c0) begin
      for (int i = 0; i < 5; i++) nw[i] = c_s;
    end else begin
      for (int i = 0; i < 4; i++) nw[i] = win[i+1];
      nw[4] = c_s;
    end
    r_tail = '{detail: detail_f(hsum(win[2], win[3], win[4], win[4], win[4]), dly[2],
                                output_mode),
               frame_end: c_ctl.tail_fend, run_end: 1'b0};
    r_e2   = '{detail: detail_f(hsum(nw[0], nw[1], nw[2], nw[3], nw[4]), dly[1], output_mode),
               frame_end: 1'b0, run_end: 1'b0};
    r_e3   = '{detail: detail_f(hsum(nw[1], nw[2], nw[3], nw[4], nw[4]), dly[2], output_mode),
               frame_end: 1'b0, run_end: 1'b0};
    sl0 = r_e2;
    sl1 = r_e3;
    n   = 2'd0;
    priority if (c_ctl.tail) begin
      sl0 = r_tail;
      n   = 2'd1;
    end else if (c_ctl.emit2) begin
      n = c_ctl.emit3 ? 2'd2 : 2'd1;
    end else if (c_ctl.emit3) begin
      sl0 = r_e3;
      n   = 2'd1;
    end
    if (n == 2'd1) sl0.run_end = 1'b1;
    if (n == 2'd2) sl1.run_end = 1'b1;
    push = c_v ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) win[i] <= '0;
      for (int i = 0; i < 3; i++) dly[i] <= '0;
    end else if (c_v && c_ctl.have) begin
      for (int i = 0; i < 5; i++) win[i] <= nw[i];
      dly[0] <= dly[1];
      dly[1] <= dly[2];
      dly[2] <= c_center;
    end
  end

  // ---------------- output queue ----------------
  res_t               fd [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;
  logic [FIFO_AW:0]   cnt;
  logic [FIFO_AW+1:0] need;
  logic               pop;

  assign pop  = res_out.valid && res_out.ready;
  // room for everything in flight plus one more item
  assign need = (FIFO_AW+2)'(cnt) + ((FIFO_AW+2)'(b_v) << 1) + ((FIFO_AW+2)'(c_v) << 1)
              + (FIFO_AW+2)'(2);

  assign pix_in.ready      = need <= (FIFO_AW+2)'(FIFO_DEPTH);
  assign res_out.valid     = cnt != '0;
  assign res_out.detail    = fd[rp].detail;
  assign res_out.frame_end = fd[rp].frame_end;
  assign res_out.run_end   = fd[rp].run_end;

  always_ff @(posedge clk) begin
    if (push != 2'd0) fd[wp] <= sl0;
    if (push == 2'd2) fd[wp + FIFO_AW'(1)] <= sl1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + FIFO_AW'(push);
      rp  <= rp + FIFO_AW'(pop);
      cnt <= cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    b_v |=> c_v)
    else $error("item lost between vertical and horizontal pass");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && ign |=> !b_v)
    else $error("ignored flush entered the pipeline");

  a_tail_first_col: assert property (@(posedge clk) disable iff (rst)
    c_v && c_ctl.tail && c_ctl.have |-> c_ctl.c0)
    else $error("pending tail released away from column zero");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gdx_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fl;
  } pix_item_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_WAIT   = 20;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  gdx_pix_if pix_if();
  gdx_res_if res_if();

  gauss5x5_detail_extractor_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_if),
    .res_out   (res_if)
  );

  // shadow of the block state
  logic [DIM_W-1:0] width_reg, height_reg;
  logic             mode_reg;
  logic [7:0]       line_mem [0:4*MAX_WIDTH-1];
  int               col_sums [5];
  int               center_dly [3];
  int               in_col, in_row;
  logic [23:0]      out_pos;
  bit               tail_due;

  pix_item_t pending_pix[$];
  res_t      detail_q[$];

  int  send_idle, recv_idle;
  int  hold_req, hold_seen, hold_left;
  int  errors, pix_sent, pix_taken, details_checked, frames_seen, cycles;
  int  queued_items;

  always #1 clk = ~clk;

  function automatic int eff_dim(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int mem_rd(int r, int c);
    return line_mem[(r & 3) * MAX_WIDTH + (c % MAX_WIDTH)];
  endfunction

  function automatic int clamp_row(int r, int h);
    if (r < 0) return 0;
    if (r > h - 1) return h - 1;
    return r;
  endfunction

  function automatic logic [DET_W-1:0] detail_at(int k, int center);
    int v, idx, blur, d;
    int wt[5];
    wt = '{1, 4, 6, 4, 1};
    v = 0;
    for (int j = 0; j < 5; j++) begin
      idx = k + j - 2;
      if (idx > 4) idx = 4;
      v += wt[j] * col_sums[idx];
    end
    blur = (v + 128) >> 8;
    d = center - blur;
    if (mode_reg) begin
      d += 128;
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      if (d >= 127 && d <= 129) d = 128;
    end
    return d[DET_W-1:0];
  endfunction

  task automatic predict_details(input logic [7:0] pix, input logic fl);
    int   w, h, r, c, s, cur, center;
    bit   done, go;
    res_t outs[$];
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    done = in_row >= h + 2;
    go = !(!done && fl && in_row < h);
    if (go && tail_due) begin
      outs.push_back('{detail_at(4, center_dly[2]),
                       out_pos == 24'((w * h - 1) % (1 << 24)), 1'b0});
      out_pos = out_pos + 24'd1;
      tail_due = 0;
    end
    if (go && done) begin
      out_pos = 0;
      in_row = 0;
      in_col = 0;
      if (fl) go = 0;
    end
    if (go) begin
      r = in_row;
      c = in_col;
      s = 0;
      if (r >= 2) begin
        s = mem_rd(clamp_row(r - 4, h), c) + 4 * mem_rd(clamp_row(r - 3, h), c)
          + 6 * mem_rd(clamp_row(r - 2, h), c) + 4 * mem_rd(clamp_row(r - 1, h), c);
        cur = (r < h) ? pix : mem_rd(h - 1, c);
        s += cur;
      end
      if (r < h && !fl) line_mem[(r & 3) * MAX_WIDTH + c] = pix;
      if (r >= 2) begin
        center = mem_rd(clamp_row(r - 2, h), c);
        if (c == 0) begin
          for (int i = 0; i < 5; i++) col_sums[i] = s;
        end else begin
          for (int i = 0; i < 4; i++) col_sums[i] = col_sums[i+1];
          col_sums[4] = s;
        end
        center_dly[0] = center_dly[1];
        center_dly[1] = center_dly[2];
        center_dly[2] = center;
        if (c >= 2 && outs.size() < 2) begin
          outs.push_back('{detail_at(2, center_dly[0]), 1'b0, 1'b0});
          out_pos = out_pos + 24'd1;
        end
        if (c == w - 1) begin
          if (c >= 1 && outs.size() < 2) begin
            outs.push_back('{detail_at(3, center_dly[1]), 1'b0, 1'b0});
            out_pos = out_pos + 24'd1;
          end
          tail_due = 1;
        end
      end
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = r + 1;
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].run_end = 1'b1;
    foreach (outs[i]) detail_q.push_back(outs[i]);
  endtask

  // sender
  always @(posedge clk) begin
    pix_item_t it;
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (pending_pix.size() > 0 && $urandom_range(99) >= send_idle) begin
        it = pending_pix.pop_front();
        pix_if.valid <= 1'b1;
        pix_if.pixel <= it.pix;
        pix_if.flush <= it.fl;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // check results, then predict from the input transfer of this edge
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (detail_q.size() == 0) begin
          $error("unexpected result: detail %0d", res_if.detail);
          errors++;
        end else begin
          exp_r = detail_q.pop_front();
          details_checked++;
          if (res_if.frame_end) frames_seen++;
          if (res_if.detail !== exp_r.detail) begin
            $error("detail: expected %0d, got %0d", $signed(exp_r.detail), res_if.detail);
            errors++;
          end
          if (res_if.frame_end !== exp_r.frame_end) begin
            $error("frame_end: expected %0b, got %0b", exp_r.frame_end, res_if.frame_end);
            errors++;
          end
          if (res_if.run_end !== exp_r.run_end) begin
            $error("run_end: expected %0b, got %0b", exp_r.run_end, res_if.run_end);
            errors++;
          end
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        pix_taken++;
        predict_details(pix_if.pixel, pix_if.flush);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] p, input logic f);
    pending_pix.push_back('{p, f});
    queued_items++;
  endtask

  task automatic wait_idle();
    while (pending_pix.size() != 0 || detail_q.size() != 0 || pix_if.valid)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      default:    mode_reg = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic start_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input bit m);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, DIM_W'(m));
  endtask

  // one frame of random pixels with noise; close=0 lets the next frame's first
  // pixel release the final result
  task automatic gen_frame(input int noise_pct, input bit close);
    int w, h;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) push_item(PIX_W'($urandom), 1'b1);
      push_item(PIX_W'($urandom), 1'b0);
    end
    for (int i = 0; i < 2 * w; i++)
      push_item(PIX_W'($urandom), ($urandom_range(99) >= noise_pct));
    if (close) push_item(PIX_W'($urandom), 1'b1);
  endtask

  initial begin
    int nf, rp;
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    pix_if.valid = 0;
    pix_if.pixel = '0;
    pix_if.flush = 0;
    res_if.ready = 0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    mode_reg = 0;
    col_sums = '{default: 0};
    center_dly = '{default: 0};
    in_col = 0; in_row = 0; out_pos = 0; tail_due = 0;
    hold_req = 0; errors = 0; cycles = 0; queued_items = 0;
    send_idle = 10; recv_idle = 68;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, stray flush, pixel in the drain, chained frame
    for (int m = 0; m < 2; m++) begin
      start_phase(DIM_W'(3), DIM_W'(3), m[0]);
      push_item(8'd0, 1'b0); push_item(8'd255, 1'b0); push_item(8'd255, 1'b1);
      push_item(8'd0, 1'b0); push_item(8'd255, 1'b0); push_item(8'd0, 1'b0);
      push_item(8'd255, 1'b0); push_item(8'd255, 1'b0); push_item(8'd0, 1'b0);
      push_item(8'd255, 1'b0);
      for (int i = 0; i < 6; i++) push_item(8'hA5, (i != 2));
      push_item(8'd128, 1'b0);
      for (int i = 0; i < 8; i++) push_item(PIX_W'(255 * (i & 1)), 1'b0);
      for (int i = 0; i < 7; i++) push_item(8'h5A, 1'b1);
    end
    start_phase('0, '0, 1'b1);
    gen_frame(0, 1'b0);
    gen_frame(0, 1'b1);

    // random frames, mostly small
    rp = 0;
    while (queued_items < 800) begin
      if (queued_items < 300) begin
        send_idle = 10; recv_idle = 68;
      end else if (queued_items < 550) begin
        send_idle = 68; recv_idle = 10;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      start_phase(DIM_W'(($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8)),
                  DIM_W'($urandom_range(1, 6)), $urandom_range(1) != 0);
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) gen_frame(8, f == nf - 1);
      if (rp == 2) hold_req++;
      rp++;
    end

    wait_idle();
    $display("Checked %0d results from %0d input transfers over %0d frames,",
             details_checked, pix_taken, frames_seen);
    $display("both output modes, zero dimensions, stray flushes, drain pixels, chained frames.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
